// ===== rtl/core/mscc_pkg.sv =====
package mscc_pkg;

  localparam int unsigned VALUE_W = 16;

  typedef struct packed {
    logic                      opcode;
    logic [1:0]                matrix_select;
    logic [1:0]                row;
    logic [1:0]                column;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic is_similar;
  } out_item_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic [1:0] SEL_A    = 2'd0;
  localparam logic [1:0] SEL_M    = 2'd1;
  localparam logic [1:0] SEL_MINV = 2'd2;
  localparam logic [1:0] SEL_B    = 2'd3;

  // operand pair fed to the shared multiplier
  typedef enum logic [1:0] {
    RD_NONE,
    RD_PB,
    RD_PM_LO,
    RD_PM_HI
  } rd_sel_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_LOOP,
    JMP_EMIT
  } jmp_e;

  localparam int unsigned PC_W  = 3;
  localparam int unsigned NSTEP = 5;

  localparam logic [PC_W-1:0] ST_P1    = 3'd0;
  localparam logic [PC_W-1:0] ST_P2LO  = 3'd1;
  localparam logic [PC_W-1:0] ST_P2HI  = 3'd2;
  localparam logic [PC_W-1:0] ST_DRAIN = 3'd3;
  localparam logic [PC_W-1:0] ST_EMIT  = 3'd4;

  typedef struct packed {
    rd_sel_e         rd;
    logic            first_k0;
    logic            shift_hi;
    logic            wr_last;
    logic            cmp_last;
    logic            adv;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
  } ucode_t;

  // p = minv * b, then a == p * m with p split in two halves
  localparam ucode_t UCODE [NSTEP] = '{
    '{rd: RD_PB,    first_k0: 1'b1, shift_hi: 1'b0, wr_last: 1'b1, cmp_last: 1'b0,
      adv: 1'b1, jmp: JMP_LOOP, target: ST_P1},
    '{rd: RD_PM_LO, first_k0: 1'b1, shift_hi: 1'b0, wr_last: 1'b0, cmp_last: 1'b0,
      adv: 1'b0, jmp: JMP_NEXT, target: ST_P2LO},
    '{rd: RD_PM_HI, first_k0: 1'b0, shift_hi: 1'b1, wr_last: 1'b0, cmp_last: 1'b1,
      adv: 1'b1, jmp: JMP_LOOP, target: ST_P2LO},
    '{rd: RD_NONE,  first_k0: 1'b0, shift_hi: 1'b0, wr_last: 1'b0, cmp_last: 1'b0,
      adv: 1'b0, jmp: JMP_NEXT, target: ST_DRAIN},
    '{rd: RD_NONE,  first_k0: 1'b0, shift_hi: 1'b0, wr_last: 1'b0, cmp_last: 1'b0,
      adv: 1'b0, jmp: JMP_EMIT, target: ST_EMIT}
  };

  typedef struct packed {
    rd_sel_e rd;
    logic    first;
    logic    shift_hi;
    logic    wr_p;
    logic    cmp;
  } ex_ctrl_t;

endpackage

// ===== rtl/core/mscc_if.sv =====
interface mscc_in_if import mscc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mscc_out_if import mscc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/matrix_similarity_check_3x3_top.sv =====
// Similarity check A == Minv * B * M on DIM x DIM signed matrices.
// Input channel in_i carries one item per handshake: a load item (opcode 0)
// writes one element of A, M, Minv or B at row/column; a check item
// (opcode 1) runs the product and compare. Loads with row or column at DIM
// or above are dropped. Output channel out_o carries one is_similar item per
// check item and nothing for loads.
// A load leaves in_i.ready high. A check holds
// in_i.ready low while the microcode sequencer runs: the P1 loop for
// Minv*B, the P2LO/P2HI loop for the second product (each term of it is two
// passes through the single multiplier, low and high half of P), then the
// DRAIN and EMIT steps finish the compare and load the output register. The
// result shows on out_o in the same cycle in which in_i.ready rises again.
// If out_o stalls, loads are still taken; a later check waits in its final
// step until the pending result is taken.
// Reset clears the sequencer and the output valid; the matrix stores keep
// no reset value and must be loaded before a check reads them.
module matrix_similarity_check_3x3_top import mscc_pkg::*; #(
  parameter int DIM           = 3,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mscc_in_if.sink     in_i,
  mscc_out_if.source  out_o
);

  localparam int NC      = DIM * DIM;
  localparam int IW      = $clog2(DIM);
  localparam int AW      = $clog2(NC);
  localparam int EW      = ELEMENT_WIDTH;
  localparam int G       = $clog2(DIM);
  localparam int PW_FULL = 2 * EW + G;
  localparam int PW      = (PW_FULL > 64) ? 64 : PW_FULL;
  localparam int FW_FULL = PW + EW + G;
  localparam int FW      = (FW_FULL > 64) ? 64 : FW_FULL;
  localparam int H       = PW / 2;
  localparam int BW      = PW - H;
  localparam int MBW     = BW + 1;
  localparam int MPW     = EW + MBW;
  localparam int XW      = (MPW > FW) ? MPW : FW;

  localparam logic [IW-1:0] IDX_LAST = IW'(DIM - 1);

  logic signed [EW-1:0] a_mem    [NC];
  logic signed [EW-1:0] m_mem    [NC];
  logic signed [EW-1:0] minv_mem [NC];
  logic signed [EW-1:0] b_mem    [NC];
  logic        [PW-1:0] p_mem    [NC];

  logic signed [EW-1:0] a_rd_q, m_rd_q, minv_rd_q, b_rd_q;
  logic        [PW-1:0] p_rd_q;
  logic        [AW-1:0] ex_addr_q;

  logic                  running_q, running_d;
  logic [PC_W-1:0]       pc_q, pc_d;
  logic [IW-1:0]         i_q, i_d, j_q, j_d, k_q, k_d;
  logic                  mismatch_q, mismatch_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_sim_q, out_sim_d;
  ex_ctrl_t              ex_q, ex_d;
  logic signed [FW-1:0]  acc_q;

  logic                  in_acc, ld_ok;
  logic [AW-1:0]         ld_addr, addr_ik, addr_kj, addr_ij;
  logic [EW-1:0]         ld_elem;
  ucode_t                uw;
  logic                  k_last, j_last, i_last, all_last, out_free;

  logic signed [EW-1:0]  op_a;
  logic signed [MBW-1:0] op_b;
  logic signed [MPW-1:0] prod;
  logic signed [XW-1:0]  prod_x, prod_sh;
  logic signed [FW-1:0]  term, sum, a_ext;

  assign in_acc  = in_i.valid && in_i.ready;
  assign ld_ok   = (32'(in_i.data.row) < DIM) && (32'(in_i.data.column) < DIM);
  assign ld_addr = AW'(32'(in_i.data.row) * DIM + 32'(in_i.data.column));

  if (EW <= VALUE_W) begin : g_elem_narrow
    assign ld_elem = in_i.data.value[EW-1:0];
  end else begin : g_elem_wide
    assign ld_elem = {{(EW - VALUE_W){1'b0}}, in_i.data.value};
  end

  assign addr_ik = AW'(32'(i_q) * DIM + 32'(k_q));
  assign addr_kj = AW'(32'(k_q) * DIM + 32'(j_q));
  assign addr_ij = AW'(32'(i_q) * DIM + 32'(j_q));

  // element loads
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_i.data.opcode == OP_LOAD) && ld_ok) begin
      unique case (in_i.data.matrix_select)
        SEL_A:    a_mem[ld_addr]    <= ld_elem;
        SEL_M:    m_mem[ld_addr]    <= ld_elem;
        SEL_MINV: minv_mem[ld_addr] <= ld_elem;
        SEL_B:    b_mem[ld_addr]    <= ld_elem;
      endcase
    end
  end

  // registered reads and partial product write-back
  always_ff @(posedge clk_i) begin
    a_rd_q    <= a_mem[addr_ij];
    m_rd_q    <= m_mem[addr_kj];
    minv_rd_q <= minv_mem[addr_ik];
    b_rd_q    <= b_mem[addr_kj];
    p_rd_q    <= p_mem[addr_ik];
    ex_addr_q <= addr_ij;
    if (ex_q.wr_p) begin
      p_mem[ex_addr_q] <= sum[PW-1:0];
    end
  end

  // execute stage, registered behind the sequencer
  always_comb begin
    unique case (ex_q.rd)
      RD_PB: begin
        op_a = minv_rd_q;
        op_b = MBW'(b_rd_q);
      end
      RD_PM_LO: begin
        op_a = m_rd_q;
        op_b = $signed({{(MBW - H){1'b0}}, p_rd_q[H-1:0]});
      end
      RD_PM_HI: begin
        op_a = m_rd_q;
        op_b = MBW'($signed(p_rd_q[PW-1:H]));
      end
      RD_NONE: begin
        op_a = m_rd_q;
        op_b = '0;
      end
    endcase
  end

  assign prod    = op_a * op_b;
  assign prod_x  = XW'(prod);
  assign prod_sh = ex_q.shift_hi ? (prod_x <<< H) : prod_x;
  assign term    = prod_sh[FW-1:0];
  assign sum     = (ex_q.first ? '0 : acc_q) + term;
  assign a_ext   = FW'(a_rd_q);

  always_ff @(posedge clk_i) begin
    if (ex_q.rd != RD_NONE) begin
      acc_q <= sum;
    end
  end

  // sequencer
  assign uw       = UCODE[pc_q];
  assign k_last   = (k_q == IDX_LAST);
  assign j_last   = (j_q == IDX_LAST);
  assign i_last   = (i_q == IDX_LAST);
  assign all_last = k_last && j_last && i_last;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    running_d   = running_q;
    pc_d        = pc_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    mismatch_d  = mismatch_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_sim_d   = out_sim_q;
    ex_d        = '{rd: RD_NONE, first: 1'b0, shift_hi: 1'b0, wr_p: 1'b0, cmp: 1'b0};

    if (ex_q.cmp && (sum != a_ext)) begin
      mismatch_d = 1'b1;
    end

    if (!running_q) begin
      if (in_acc && (in_i.data.opcode == OP_CHECK)) begin
        running_d  = 1'b1;
        pc_d       = ST_P1;
        i_d        = '0;
        j_d        = '0;
        k_d        = '0;
        mismatch_d = 1'b0;
      end
    end else begin
      ex_d.rd       = uw.rd;
      ex_d.first    = uw.first_k0 && (k_q == '0);
      ex_d.shift_hi = uw.shift_hi;
      ex_d.wr_p     = uw.wr_last && k_last;
      ex_d.cmp      = uw.cmp_last && k_last;

      if (uw.adv) begin
        if (!k_last) begin
          k_d = k_q + 1'b1;
        end else begin
          k_d = '0;
          if (!j_last) begin
            j_d = j_q + 1'b1;
          end else begin
            j_d = '0;
            i_d = i_last ? '0 : i_q + 1'b1;
          end
        end
      end

      unique case (uw.jmp)
        JMP_NEXT: pc_d = pc_q + 1'b1;
        JMP_LOOP: pc_d = all_last ? pc_q + 1'b1 : uw.target;
        JMP_EMIT: begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_sim_d   = !mismatch_q;
            running_d   = 1'b0;
          end
        end
        default: pc_d = ST_P1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      pc_q        <= ST_P1;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      mismatch_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ex_q        <= '{rd: RD_NONE, first: 1'b0, shift_hi: 1'b0, wr_p: 1'b0, cmp: 1'b0};
    end else begin
      running_q   <= running_d;
      pc_q        <= pc_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      mismatch_q  <= mismatch_d;
      out_valid_q <= out_valid_d;
      ex_q        <= ex_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sim_q <= out_sim_d;
  end

  assign in_i.ready  = !running_q;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = '{is_similar: out_sim_q};

endmodule

// ===== rtl/core/mscc_checker.sv =====
module mscc_checker import mscc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_opcode_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_is_similar_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a check item blocks the input while it runs
  a_check_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_opcode_i == OP_CHECK) |=> !in_ready_i)
    else $error("input ready after a check item");

  // a load item never causes a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_opcode_i == OP_LOAD) && !out_valid_i |=> !out_valid_i)
    else $error("result after a load item");

  // a result only appears at the end of a check run
  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result without a running check");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_is_similar_i))
    else $error("stalled result changed");

endmodule

bind matrix_similarity_check_3x3_top mscc_checker u_mscc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_opcode_i      (in_i.data.opcode),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_is_similar_i (out_o.data.is_similar)
);

// ===== tb/sv/matrix_similarity_check_3x3_top_tb.sv =====
`timescale 1ns / 1ps

class similarity_scoreboard;
  localparam int DIM = 3;
  localparam int CELLS = DIM * DIM;

  logic signed [15:0] mats [4][CELLS];
  longint             product [CELLS];
  bit                 similar_q [$];
  int                 errors;

  function new();
    errors = 0;
  endfunction

  // minv * b * m at full width
  function void compute_product();
    longint p [CELLS];
    longint acc;
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        acc = 0;
        for (int k = 0; k < DIM; k++) begin
          acc += longint'(mats[mscc_pkg::SEL_MINV][i*DIM+k]) *
                 longint'(mats[mscc_pkg::SEL_B][k*DIM+j]);
        end
        p[i*DIM+j] = acc;
      end
    end
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        acc = 0;
        for (int k = 0; k < DIM; k++) begin
          acc += p[i*DIM+k] * longint'(mats[mscc_pkg::SEL_M][k*DIM+j]);
        end
        product[i*DIM+j] = acc;
      end
    end
  endfunction

  function void note_accepted_item(mscc_pkg::in_item_t it);
    bit same;
    if (it.opcode == mscc_pkg::OP_LOAD) begin
      if (it.row < DIM && it.column < DIM) begin
        mats[it.matrix_select][it.row*DIM+it.column] = it.value;
      end
    end else begin
      compute_product();
      same = 1'b1;
      for (int n = 0; n < CELLS; n++) begin
        if (product[n] != longint'(mats[mscc_pkg::SEL_A][n])) same = 1'b0;
      end
      similar_q.push_back(same);
    end
  endfunction

  function void check_similarity_result(mscc_pkg::out_item_t r);
    bit exp_flag;
    if (similar_q.size() == 0) begin
      $display("%0t: is_similar with nothing expected, expected none, actual %0b",
               $time, r.is_similar);
      errors++;
    end else begin
      exp_flag = similar_q.pop_front();
      if (r.is_similar !== exp_flag) begin
        $display("%0t: is_similar mismatch, expected %0b, actual %0b",
                 $time, exp_flag, r.is_similar);
        errors++;
      end
    end
  endfunction

  function int pending();
    return similar_q.size();
  endfunction
endclass

module matrix_similarity_check_3x3_top_tb;
  import mscc_pkg::*;

  localparam int DIM         = 3;
  localparam int CELLS       = DIM * DIM;
  localparam int RAND_ITEMS  = 340;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 100;
  localparam int IDLE_LIMIT  = 5000;

  localparam logic [1:0] SRC_SEL [3] = '{SEL_M, SEL_MINV, SEL_B};
  localparam logic signed [15:0] EDGE_VALS [CELLS] = '{
    16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001,
    16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00
  };

  logic clk_i;
  logic rst_ni;

  mscc_in_if  in_if ();
  mscc_out_if out_if ();

  similarity_scoreboard sb = new();

  int items;
  int checks_sent;
  int idle_cycles;
  bit burst;

  matrix_similarity_check_3x3_top #(
    .DIM          (DIM),
    .ELEMENT_WIDTH(16)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_similarity_result(out_if.data);
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int r;
    int n;
    bit held;
    held = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && checks_sent >= 6) begin
        // long stall so the block fills and holds off its input
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_if.ready <= 1'b1;
          n = $urandom_range(1, 20);
        end else if (r < 90) begin
          out_if.ready <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          out_if.ready <= 1'b0;
          n = $urandom_range(10, 60);
        end
        repeat (n - 1) @(posedge clk_i);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [15:0] rand_val();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 16'(int'($urandom_range(0, 20)) - 10);
    if (r < 92) return 16'(int'($urandom_range(0, 600)) - 300);
    return 16'($urandom);
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_accepted_item(it);
    if (it.opcode == OP_CHECK) begin
      items++;
      checks_sent++;
    end else if (it.row < DIM && it.column < DIM) begin
      items++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_cell(input logic [1:0] sel, input int r, input int c,
                           input logic signed [15:0] v);
    in_item_t it;
    it.opcode        = OP_LOAD;
    it.matrix_select = sel;
    it.row           = r[1:0];
    it.column        = c[1:0];
    it.value         = v;
    send_item(it);
  endtask

  task automatic send_check();
    in_item_t it;
    it.opcode = OP_CHECK;
    {it.matrix_select, it.row, it.column} = 6'($urandom);
    it.value = 16'($urandom);
    send_item(it);
  endtask

  // load with row or column out of range
  task automatic send_noise();
    int r;
    int c;
    case ($urandom_range(0, 2))
      0: begin
        r = DIM;
        c = $urandom_range(0, 3);
      end
      1: begin
        r = $urandom_range(0, 3);
        c = DIM;
      end
      default: begin
        r = DIM;
        c = DIM;
      end
    endcase
    load_cell(2'($urandom), r, c, 16'($urandom));
  endtask

  task automatic load_a_from_product(input bit corrupt);
    logic signed [15:0] v;
    int bad;
    sb.compute_product();
    bad = $urandom_range(0, CELLS - 1);
    for (int n = 0; n < CELLS; n++) begin
      if (sb.product[n] >= -32768 && sb.product[n] <= 32767) v = 16'(sb.product[n]);
      else v = 16'($urandom);
      if (corrupt && n == bad) v = v + 16'sd1;
      load_cell(SEL_A, n / DIM, n % DIM, v);
    end
  endtask

  task automatic full_set(input bit corrupt);
    int order [3*CELLS];
    int j;
    int t;
    for (int i = 0; i < 3*CELLS; i++) order[i] = i;
    for (int i = 3*CELLS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < 3*CELLS; i++) begin
      if ($urandom_range(0, 99) < 8) send_noise();
      load_cell(SRC_SEL[order[i] / CELLS], (order[i] % CELLS) / DIM,
                order[i] % DIM, rand_val());
    end
    load_a_from_product(corrupt);
    send_check();
  endtask

  task automatic few_loads();
    int n;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      load_cell(2'($urandom), $urandom_range(0, 2), $urandom_range(0, 2), rand_val());
    end
    if ($urandom_range(0, 99) < 15) send_noise();
    send_check();
  endtask

  task automatic raw_items();
    in_item_t it;
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      it = 23'($urandom);
      send_item(it);
    end
  endtask

  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin : stimulus
    int kind;
    int target;
    int next_pause;
    items       = 0;
    checks_sent = 0;
    idle_cycles = 0;
    burst       = 1'b0;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // out of range loads before anything is written
    load_cell(SEL_A, DIM, 0, 16'sh7FFF);
    load_cell(SEL_M, 0, DIM, 16'sh8000);
    load_cell(SEL_B, DIM, DIM, 16'shFFFF);
    // identity transforms, b and a at the value extremes
    for (int n = 0; n < CELLS; n++) begin
      load_cell(SEL_M, n / DIM, n % DIM, (n / DIM == n % DIM) ? 16'sd1 : 16'sd0);
      load_cell(SEL_MINV, n / DIM, n % DIM, (n / DIM == n % DIM) ? 16'sd1 : 16'sd0);
      load_cell(SEL_B, n / DIM, n % DIM, EDGE_VALS[n]);
      load_cell(SEL_A, n / DIM, n % DIM, EDGE_VALS[n]);
    end
    send_check();
    load_cell(SEL_A, 1, 1, 16'sd2);
    send_check();
    load_cell(SEL_A, 1, 1, 16'sd1);
    load_cell(SEL_A, 1, DIM, 16'sd7);
    send_check();
    // element (0,0) gets a full width product whose low 16 bits match a
    load_cell(SEL_MINV, 0, 0, 16'sd256);
    load_cell(SEL_A, 0, 0, 16'sd0);
    send_check();
    wait_results_drained();

    target     = items + RAND_ITEMS;
    next_pause = items + 150;
    while (items < target) begin
      burst = ($urandom_range(0, 4) == 0);
      kind  = $urandom_range(0, 99);
      if (kind < 30) full_set($urandom_range(0, 3) == 0);
      else if (kind < 50) begin
        load_a_from_product($urandom_range(0, 9) < 3);
        send_check();
      end else if (kind < 85) few_loads();
      else raw_items();
      if (items >= next_pause) begin
        wait_results_drained();
        next_pause += 150;
      end
    end

    wait_results_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
